// File: hw/rtl/itlf_pkg.sv
// Shared types and constants for the isolation tree leaf finder.
// Holds the action codes and the packed layout of one node table entry.
// No dependencies.
package itlf_pkg;

    typedef logic [1:0] action_t;

    localparam action_t ACT_NODE_WRITE    = 2'd0;
    localparam action_t ACT_FEATURE_WRITE = 2'd1;
    localparam action_t ACT_CLASSIFY      = 2'd2;

    // Factor splits carry a 32-bit level mask, so levels 1..32 can go left.
    localparam int unsigned FACTOR_LEVELS = 32;

    localparam int unsigned NODE_ENTRY_W = 64;

    typedef struct packed {
        logic [7:0]  right;
        logic [7:0]  left;
        logic [31:0] split_value;
        logic        is_factor;
        logic [5:0]  split_feature;
        logic [7:0]  terminal_id;
        logic        is_leaf;
    } node_entry_t;

endpackage

// File: hw/rtl/isolation_tree_leaf_finder.sv
// Channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | action, tree_index, node_*, feature_index/value
// out      | out_valid / out_stall| terminal_id, path_depth, walk_error
//
// Node and feature writes are taken while the sequencer is idle. In a classify walk,
// each level needs one node table read and then one feature store read, both
// through registered RAM ports, feeding one shared compare unit.
// The input is stalled while a walk runs and while its result waits for the
// output register. Reset clears the sequencer and the output valid only; the
// node table and feature store are undefined until written, with no clearing pass.
// A finished result sits in the output register, so writes are taken while it waits.
//
// Top level of the isolation tree leaf finder.
// Depends on itlf_pkg and itlf_ram.
module isolation_tree_leaf_finder #(
    parameter int TREE_COUNT     = 8,
    parameter int NODES_PER_TREE = 256,
    parameter int FEATURE_COUNT  = 64
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  itlf_pkg::action_t action,
    input  logic [2:0]        tree_index,
    input  logic [7:0]        node_index,
    input  logic              node_is_leaf,
    input  logic [7:0]        node_terminal_id,
    input  logic [5:0]        node_split_feature,
    input  logic              node_is_factor,
    input  logic signed [31:0] node_split_value,
    input  logic [7:0]        node_left,
    input  logic [7:0]        node_right,
    input  logic [5:0]        feature_index,
    input  logic signed [31:0] feature_value,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        terminal_id,
    output logic [7:0]        path_depth,
    output logic              walk_error
);

    import itlf_pkg::*;

    localparam int TABLE_DEPTH = TREE_COUNT * NODES_PER_TREE;
    localparam int NA_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FA_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int DW   = $clog2(NODES_PER_TREE + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NODE = 3'd1;
    localparam logic [2:0] S_FEAT = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]      state_reg, state_next;
    logic [NA_W-1:0] base_reg, base_next;
    logic [7:0]      slot_reg, slot_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [31:0]     split_reg, split_next;
    logic            factor_reg, factor_next;
    logic [7:0]      left_reg, left_next;
    logic [7:0]      right_reg, right_next;
    logic            feat_oor_reg, feat_oor_next;
    logic [7:0]      res_term_reg, res_term_next;
    logic            res_err_reg, res_err_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_term_reg, out_term_next;
    logic [7:0]      out_depth_reg, out_depth_next;
    logic            out_err_reg, out_err_next;

    logic            in_xfer;
    logic            tree_ok;
    logic [NA_W-1:0] base_comb;
    logic            node_we;
    logic [NA_W-1:0] node_waddr;
    logic [NA_W-1:0] node_raddr;
    logic [NODE_ENTRY_W-1:0] node_rdata;
    node_entry_t     wr_entry;
    node_entry_t     node_rd;
    logic            feat_we;
    logic [31:0]     feat_rdata;
    logic [31:0]     feat_x;
    logic [31:0]     level_m1;
    logic            go_left;
    logic [7:0]      child;
    logic            out_load;
    logic [7:0]      depth_sat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign tree_ok  = (32'(tree_index) < 32'(TREE_COUNT));
    assign base_comb = NA_W'(32'(tree_index) * 32'(NODES_PER_TREE));

    assign wr_entry.right         = node_right;
    assign wr_entry.left          = node_left;
    assign wr_entry.split_value   = node_split_value;
    assign wr_entry.is_factor     = node_is_factor;
    assign wr_entry.split_feature = node_split_feature;
    assign wr_entry.terminal_id   = node_terminal_id;
    assign wr_entry.is_leaf       = node_is_leaf;

    assign node_we = in_xfer && (action == ACT_NODE_WRITE) && tree_ok
                     && (32'(node_index) < 32'(NODES_PER_TREE));
    assign node_waddr = base_comb + NA_W'(node_index);
    assign feat_we = in_xfer && (action == ACT_FEATURE_WRITE)
                     && (32'(feature_index) < 32'(FEATURE_COUNT));

    assign node_rd = node_entry_t'(node_rdata);

    // The shared compare unit: numeric threshold or factor mask lookup.
    assign feat_x   = feat_oor_reg ? 32'd0 : feat_rdata;
    assign level_m1 = feat_x - 32'd1;
    always_comb
    begin
        if (factor_reg)
        begin
            go_left = (feat_x >= 32'd1) && (feat_x <= 32'(FACTOR_LEVELS))
                      && split_reg[level_m1[4:0]];
        end
        else
        begin
            go_left = ($signed(feat_x) < $signed(split_reg));
        end
    end
    assign child = go_left ? left_reg : right_reg;

    // In idle the root of the addressed tree is fetched; during a walk the child.
    assign node_raddr = (state_reg == S_IDLE) ? base_comb : (base_reg + NA_W'(child));

    assign depth_sat = (32'(depth_reg) > 32'd255) ? 8'hFF : 8'(depth_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        slot_next     = slot_reg;
        depth_next    = depth_reg;
        split_next    = split_reg;
        factor_next   = factor_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        feat_oor_next = feat_oor_reg;
        res_term_next = res_term_reg;
        res_err_next  = res_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (action == ACT_CLASSIFY))
                begin
                    base_next     = base_comb;
                    slot_next     = 8'd0;
                    depth_next    = '0;
                    res_term_next = 8'd0;
                    if (tree_ok)
                    begin
                        res_err_next = 1'b0;
                        state_next   = S_NODE;
                    end
                    else
                    begin
                        res_err_next = 1'b1;
                        state_next   = S_DONE;
                    end
                end
            end
            S_NODE:
            begin
                split_next    = node_rd.split_value;
                factor_next   = node_rd.is_factor;
                left_next     = node_rd.left;
                right_next    = node_rd.right;
                feat_oor_next = (32'(node_rd.split_feature) >= 32'(FEATURE_COUNT));
                if (node_rd.is_leaf)
                begin
                    res_term_next = node_rd.terminal_id;
                    state_next    = S_DONE;
                end
                else if (32'(depth_reg) >= 32'(NODES_PER_TREE))
                begin
                    res_err_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_FEAT;
                end
            end
            S_FEAT:
            begin
                slot_next  = child;
                depth_next = depth_reg + DW'(1);
                if (32'(child) >= 32'(NODES_PER_TREE))
                begin
                    res_err_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_NODE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_term_next  = out_term_reg;
        out_depth_next = out_depth_reg;
        out_err_next   = out_err_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_term_next  = res_err_reg ? 8'd0 : res_term_reg;
            out_depth_next = res_err_reg ? 8'd0 : depth_sat;
            out_err_next   = res_err_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= 8'd0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        split_reg     <= split_next;
        factor_reg    <= factor_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        feat_oor_reg  <= feat_oor_next;
        res_term_reg  <= res_term_next;
        res_err_reg   <= res_err_next;
        out_term_reg  <= out_term_next;
        out_depth_reg <= out_depth_next;
        out_err_reg   <= out_err_next;
    end

    itlf_ram #(
        .WIDTH (NODE_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_node_table (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (wr_entry),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    itlf_ram #(
        .WIDTH (32),
        .DEPTH (FEATURE_COUNT)
    ) u_feature_store (
        .clk   (clk),
        .we    (feat_we),
        .waddr (FA_W'(feature_index)),
        .wdata (feature_value),
        .raddr (FA_W'(node_rd.split_feature)),
        .rdata (feat_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign terminal_id = out_term_reg;
    assign path_depth  = out_depth_reg;
    assign walk_error  = out_err_reg;

    // The split count never runs past the node count of one tree.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= 32'(NODES_PER_TREE))
        else $error("walk depth ran past the node count");

    // An error result carries neither a terminal id nor a depth.
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && walk_error) |-> (terminal_id == 8'd0 && path_depth == 8'd0))
        else $error("error result with nonzero fields");

    // A new result only appears after a classify reaches the done state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result raised without a finished walk");

    // A classify transfer on a valid tree starts with a node fetch.
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (action == ACT_CLASSIFY) && tree_ok) |=> (state_reg == S_NODE))
        else $error("classify did not start a walk");

endmodule

// File: hw/rtl/itlf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the node table and the feature store. No dependencies.
module itlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
